FILE: design/yfu_pkg.sv
// Shared types, codes and the micro-op program for the Yee field update engine.
// Depends on nothing; used by the controller, datapath and top level.
`default_nettype none

package yfu_pkg;

  localparam int DW     = 32;
  localparam int ACC_W  = 52;
  localparam int GRIDS  = 9;
  localparam int IDX_W  = 5;

  typedef enum logic [1:0] {
    RQ_WRITE   = 2'd0,
    RQ_CURRENT = 2'd1,
    RQ_ADVANCE = 2'd2,
    RQ_READ    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_COEF_X = 3'd0,
    CFG_COEF_Y = 3'd1,
    CFG_COEF_Z = 3'd2,
    CFG_CUR    = 3'd3,
    CFG_E0_X   = 3'd4,
    CFG_E0_Y   = 3'd5,
    CFG_E0_Z   = 3'd6
  } cfg_idx_t;

  localparam logic [2:0] FIELD_COMP_LAST = 3'd5;
  localparam logic [2:0] CUR_COMP_LAST   = 3'd2;
  localparam logic [1:0] AXIS_LAST       = 2'd2;
  localparam logic [2:0] UOP_LAST_B      = 3'd4;
  localparam logic [2:0] UOP_LAST_E      = 3'd5;
  localparam logic [1:0] DRAIN_LAST      = 2'd2;

  typedef enum logic [3:0] {
    G_EX, G_EY, G_EZ, G_BX, G_BY, G_BZ, G_JX, G_JY, G_JZ
  } grid_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_OLD, OP_A, OP_B, OP_J, OP_RD
  } op_t;

  typedef enum logic [2:0] {
    N_C, N_IP, N_IM, N_JP, N_JM, N_KP, N_KM
  } nbr_t;

  typedef enum logic [1:0] {
    C_X, C_Y, C_Z, C_CUR
  } csel_t;

  typedef enum logic [2:0] {
    W_ACC, W_SAMPLE, W_ZERO, W_E0X, W_E0Y, W_E0Z, W_CLEAR
  } wsrc_t;

  typedef enum logic [1:0] {
    PH_B1, PH_E, PH_B2
  } phase_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MOD, S_HOST, S_RDW, S_CELL, S_UOP, S_DRAIN, S_WR, S_DONE
  } state_t;

  typedef struct packed {
    op_t   op;
    grid_t grid;
    nbr_t  nbr;
    csel_t csel;
    logic  neg;
  } uop_t;

  typedef struct packed {
    uop_t  u;
    logic  half;
    logic  wr_en;
    grid_t wr_grid;
    wsrc_t wsrc;
    logic  clr_flag;
    logic  clr_res;
    logic  take_req;
    logic  load_out;
  } cmd_t;

  function automatic uop_t mk(input op_t op, input grid_t g, input nbr_t n,
                              input csel_t c, input logic neg);
    uop_t u;
    u.op   = op;
    u.grid = g;
    u.nbr  = n;
    u.csel = c;
    u.neg  = neg;
    return u;
  endfunction

  // Operand sequence for one cell update: old value, then (a, b) pairs and,
  // in the E pass, the current term. B pass subtracts the curl, E pass adds it.
  function automatic uop_t prog(input logic is_e, input logic [1:0] axis,
                                input logic [2:0] idx);
    uop_t u;
    u = mk(OP_NOP, G_EX, N_C, C_X, 1'b0);
    unique case ({is_e, axis, idx})
      {1'b0, 2'd0, 3'd0}: u = mk(OP_OLD, G_BX, N_C,  C_X,   1'b0);
      {1'b0, 2'd0, 3'd1}: u = mk(OP_A,   G_EZ, N_JP, C_X,   1'b0);
      {1'b0, 2'd0, 3'd2}: u = mk(OP_B,   G_EZ, N_C,  C_Y,   1'b1);
      {1'b0, 2'd0, 3'd3}: u = mk(OP_A,   G_EY, N_KP, C_X,   1'b0);
      {1'b0, 2'd0, 3'd4}: u = mk(OP_B,   G_EY, N_C,  C_Z,   1'b0);
      {1'b0, 2'd1, 3'd0}: u = mk(OP_OLD, G_BY, N_C,  C_X,   1'b0);
      {1'b0, 2'd1, 3'd1}: u = mk(OP_A,   G_EX, N_KP, C_X,   1'b0);
      {1'b0, 2'd1, 3'd2}: u = mk(OP_B,   G_EX, N_C,  C_Z,   1'b1);
      {1'b0, 2'd1, 3'd3}: u = mk(OP_A,   G_EZ, N_IP, C_X,   1'b0);
      {1'b0, 2'd1, 3'd4}: u = mk(OP_B,   G_EZ, N_C,  C_X,   1'b0);
      {1'b0, 2'd2, 3'd0}: u = mk(OP_OLD, G_BZ, N_C,  C_X,   1'b0);
      {1'b0, 2'd2, 3'd1}: u = mk(OP_A,   G_EY, N_IP, C_X,   1'b0);
      {1'b0, 2'd2, 3'd2}: u = mk(OP_B,   G_EY, N_C,  C_X,   1'b1);
      {1'b0, 2'd2, 3'd3}: u = mk(OP_A,   G_EX, N_JP, C_X,   1'b0);
      {1'b0, 2'd2, 3'd4}: u = mk(OP_B,   G_EX, N_C,  C_Y,   1'b0);
      {1'b1, 2'd0, 3'd0}: u = mk(OP_OLD, G_EX, N_C,  C_X,   1'b0);
      {1'b1, 2'd0, 3'd1}: u = mk(OP_A,   G_BZ, N_C,  C_X,   1'b0);
      {1'b1, 2'd0, 3'd2}: u = mk(OP_B,   G_BZ, N_JM, C_Y,   1'b0);
      {1'b1, 2'd0, 3'd3}: u = mk(OP_A,   G_BY, N_C,  C_X,   1'b0);
      {1'b1, 2'd0, 3'd4}: u = mk(OP_B,   G_BY, N_KM, C_Z,   1'b1);
      {1'b1, 2'd0, 3'd5}: u = mk(OP_J,   G_JX, N_C,  C_CUR, 1'b1);
      {1'b1, 2'd1, 3'd0}: u = mk(OP_OLD, G_EY, N_C,  C_X,   1'b0);
      {1'b1, 2'd1, 3'd1}: u = mk(OP_A,   G_BZ, N_C,  C_X,   1'b0);
      {1'b1, 2'd1, 3'd2}: u = mk(OP_B,   G_BZ, N_IM, C_X,   1'b1);
      {1'b1, 2'd1, 3'd3}: u = mk(OP_A,   G_BX, N_C,  C_X,   1'b0);
      {1'b1, 2'd1, 3'd4}: u = mk(OP_B,   G_BX, N_KM, C_Z,   1'b0);
      {1'b1, 2'd1, 3'd5}: u = mk(OP_J,   G_JY, N_C,  C_CUR, 1'b1);
      {1'b1, 2'd2, 3'd0}: u = mk(OP_OLD, G_EZ, N_C,  C_X,   1'b0);
      {1'b1, 2'd2, 3'd1}: u = mk(OP_A,   G_BY, N_C,  C_X,   1'b0);
      {1'b1, 2'd2, 3'd2}: u = mk(OP_B,   G_BY, N_IM, C_X,   1'b0);
      {1'b1, 2'd2, 3'd3}: u = mk(OP_A,   G_BX, N_C,  C_X,   1'b0);
      {1'b1, 2'd2, 3'd4}: u = mk(OP_B,   G_BX, N_JM, C_Y,   1'b1);
      {1'b1, 2'd2, 3'd5}: u = mk(OP_J,   G_JZ, N_C,  C_CUR, 1'b1);
      default:            u = mk(OP_NOP, G_EX, N_C,  C_X,   1'b0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

FILE: design/yfu_if.sv
// Request and result channel interfaces, valid/ready with payload.
// Depends on nothing.
`default_nettype none

interface yfu_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [2:0]        component;
  logic [4:0]        ix;
  logic [4:0]        iy;
  logic [4:0]        iz;
  logic signed [31:0] sample_value;
  modport source(output valid, req_type, component, ix, iy, iz, sample_value,
                 input ready);
  modport sink(input valid, req_type, component, ix, iy, iz, sample_value,
               output ready);
endinterface

interface yfu_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] read_value;
  logic              overflow_seen;
  modport source(output valid, read_value, overflow_seen, input ready);
  modport sink(input valid, read_value, overflow_seen, output ready);
endinterface

`default_nettype wire

FILE: design/yee_fdtd_field_update.sv
// Top level of the Yee field update engine: sequencer plus datapath.
// Depends on yfu_pkg, yfu_if, yfu_ctrl and yfu_dpath.
//
// Holds Ex..Ez, Bx..Bz and Jx..Jz on an (NX+1) x NY x NZ lattice in Q16.16,
// one 32-bit memory per component. After reset a clearing pass over every
// lattice point zeroes all grids; no request is taken meanwhile,
// configuration writes are. Every request returns one beat. Write, current
// write and read requests first fold an out-of-range y or z index by
// repeatedly subtracting NY or NZ. An advance makes three passes (B half
// step, E step, B half step): the B components are updated in both half
// steps, the E components in the E step. Every full update fetches its
// operands one at a time through the memories' single read port and a
// shared multiply-round-accumulate pipe; forced boundary values are written
// without the pipe. A new request is taken while the previous result waits
// in the output register.
`default_nettype none

module yee_fdtd_field_update #(
  parameter int NX = 16,
  parameter int NY = 16,
  parameter int NZ = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  yfu_req_if.sink          req,
  yfu_rsp_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IW = $clog2(NX + 1);
  localparam int JW = $clog2(NY);
  localparam int KW = $clog2(NZ);

  yfu_pkg::cmd_t cmd;
  logic [IW-1:0] ci;
  logic [JW-1:0] cj;
  logic [KW-1:0] ck;

  yfu_ctrl #(.NX(NX), .NY(NY), .NZ(NZ)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .req_type  (req.req_type),
    .component (req.component),
    .ix        (req.ix),
    .iy        (req.iy),
    .iz        (req.iz),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .ci        (ci),
    .cj        (cj),
    .ck        (ck)
  );

  yfu_dpath #(.NX(NX), .NY(NY), .NZ(NZ)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ci        (ci),
    .cj        (cj),
    .ck        (ck),
    .sample    (req.sample_value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_value (rsp.read_value),
    .out_flag  (rsp.overflow_seen)
  );

endmodule

`default_nettype wire

FILE: design/yfu_ctrl.sv
// Sequencer: request decode, clearing sweep, and the three-pass field sweep.
// Depends on yfu_pkg; drives yfu_dpath through yfu_pkg::cmd_t.
`default_nettype none

module yfu_ctrl #(
  parameter int NX = 16,
  parameter int NY = 16,
  parameter int NZ = 16,
  localparam int IW = $clog2(NX + 1),
  localparam int JW = $clog2(NY),
  localparam int KW = $clog2(NZ)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic [1:0]        req_type,
  input  wire logic [2:0]        component,
  input  wire logic [4:0]        ix,
  input  wire logic [4:0]        iy,
  input  wire logic [4:0]        iz,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      yfu_pkg::cmd_t     cmd,
  output      logic [IW-1:0]     ci,
  output      logic [JW-1:0]     cj,
  output      logic [KW-1:0]     ck
);

  yfu_pkg::state_t state, state_next;
  yfu_pkg::phase_t phase, phase_next;
  yfu_pkg::wsrc_t  fsrc, fsrc_next;
  logic [1:0]      axis, axis_next;
  logic [IW-1:0]   i, i_next;
  logic [JW-1:0]   j, j_next;
  logic [KW-1:0]   k, k_next;
  logic [2:0]      uidx, uidx_next;
  logic [1:0]      dcnt, dcnt_next;
  logic [1:0]      rtype, rtype_next;
  logic [2:0]      rcomp, rcomp_next;
  logic [4:0]      hx, hx_next;
  logic [4:0]      hy, hy_next;
  logic [4:0]      hz, hz_next;
  logic            out_valid_next;

  logic is_e, k_last, j_last, i_last, cell_last, step_cell, step_sweep;
  logic host_ok;

  assign is_e      = (phase == yfu_pkg::PH_E);
  assign k_last    = (k == KW'(NZ - 1));
  assign j_last    = (j == JW'(NY - 1));
  assign i_last    = (i == IW'(NX));
  assign cell_last = k_last && j_last && i_last;
  assign host_ok   = (int'(hx) <= NX);
  assign ci = i;
  assign cj = j;
  assign ck = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= yfu_pkg::S_CLR;
      out_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      i         <= i_next;
      j         <= j_next;
      k         <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    fsrc  <= fsrc_next;
    axis  <= axis_next;
    uidx  <= uidx_next;
    dcnt  <= dcnt_next;
    rtype <= rtype_next;
    rcomp <= rcomp_next;
    hx    <= hx_next;
    hy    <= hy_next;
    hz    <= hz_next;
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    fsrc_next      = fsrc;
    axis_next      = axis;
    uidx_next      = uidx;
    dcnt_next      = dcnt;
    rtype_next     = rtype;
    rcomp_next     = rcomp;
    hx_next        = hx;
    hy_next        = hy;
    hz_next        = hz;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    step_cell      = 1'b0;
    step_sweep     = 1'b0;
    cmd            = '0;

    unique case (state)
      yfu_pkg::S_CLR: begin
        cmd.wr_en = 1'b1;
        cmd.wsrc  = yfu_pkg::W_CLEAR;
        step_cell = 1'b1;
        if (cell_last) state_next = yfu_pkg::S_IDLE;
      end
      yfu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.clr_res  = 1'b1;
          cmd.take_req = 1'b1;
          rtype_next   = req_type;
          rcomp_next   = component;
          hx_next      = ix;
          hy_next      = iy;
          hz_next      = iz;
          if (req_type == yfu_pkg::RQ_ADVANCE) begin
            cmd.clr_flag = 1'b1;
            phase_next   = yfu_pkg::PH_B1;
            axis_next    = '0;
            i_next       = '0;
            j_next       = '0;
            k_next       = '0;
            state_next   = yfu_pkg::S_CELL;
          end else begin
            state_next = yfu_pkg::S_MOD;
          end
        end
      end
      yfu_pkg::S_MOD: begin
        if (int'(hy) >= NY) hy_next = hy - 5'(NY);
        if (int'(hz) >= NZ) hz_next = hz - 5'(NZ);
        if (int'(hy) < NY && int'(hz) < NZ) begin
          i_next     = IW'(hx);
          j_next     = JW'(hy);
          k_next     = KW'(hz);
          state_next = yfu_pkg::S_HOST;
        end
      end
      yfu_pkg::S_HOST: begin
        state_next = yfu_pkg::S_DONE;
        unique case (rtype)
          yfu_pkg::RQ_WRITE: begin
            cmd.wr_en   = host_ok && (rcomp <= yfu_pkg::FIELD_COMP_LAST);
            cmd.wr_grid = yfu_pkg::grid_t'({1'b0, rcomp});
            cmd.wsrc    = yfu_pkg::W_SAMPLE;
          end
          yfu_pkg::RQ_CURRENT: begin
            cmd.wr_en   = host_ok && (rcomp <= yfu_pkg::CUR_COMP_LAST);
            cmd.wr_grid = yfu_pkg::grid_t'(4'({1'b0, rcomp}) + 4'(yfu_pkg::G_JX));
            cmd.wsrc    = yfu_pkg::W_SAMPLE;
          end
          yfu_pkg::RQ_READ: begin
            if (host_ok && (rcomp <= yfu_pkg::FIELD_COMP_LAST)) begin
              cmd.u.op   = yfu_pkg::OP_RD;
              cmd.u.grid = yfu_pkg::grid_t'({1'b0, rcomp});
            end
            state_next = yfu_pkg::S_RDW;
          end
          default: ;
        endcase
      end
      yfu_pkg::S_RDW: state_next = yfu_pkg::S_DONE;
      yfu_pkg::S_CELL: begin
        fsrc_next = yfu_pkg::W_ACC;
        uidx_next = '0;
        if (!is_e && axis != 2'd0 && i_last) begin
          step_sweep = 1'b1;
        end else if (is_e && i_last) begin
          unique case (axis)
            2'd0:    fsrc_next = yfu_pkg::W_E0X;
            2'd1:    fsrc_next = yfu_pkg::W_E0Y;
            default: fsrc_next = yfu_pkg::W_E0Z;
          endcase
          state_next = yfu_pkg::S_WR;
        end else if (is_e && axis != 2'd0 && i == '0) begin
          fsrc_next  = yfu_pkg::W_ZERO;
          state_next = yfu_pkg::S_WR;
        end else begin
          state_next = yfu_pkg::S_UOP;
        end
      end
      yfu_pkg::S_UOP: begin
        cmd.u    = yfu_pkg::prog(is_e, axis, uidx);
        cmd.half = !is_e;
        if (uidx == (is_e ? yfu_pkg::UOP_LAST_E : yfu_pkg::UOP_LAST_B)) begin
          dcnt_next  = '0;
          state_next = yfu_pkg::S_DRAIN;
        end else begin
          uidx_next = uidx + 3'd1;
        end
      end
      yfu_pkg::S_DRAIN: begin
        dcnt_next = dcnt + 2'd1;
        if (dcnt == yfu_pkg::DRAIN_LAST) state_next = yfu_pkg::S_WR;
      end
      yfu_pkg::S_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_grid = is_e ? yfu_pkg::grid_t'({2'b00, axis})
                           : yfu_pkg::grid_t'(4'({2'b00, axis}) + 4'(yfu_pkg::G_BX));
        cmd.wsrc    = fsrc;
        step_sweep  = 1'b1;
      end
      yfu_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = yfu_pkg::S_IDLE;
        end
      end
      default: state_next = yfu_pkg::S_IDLE;
    endcase

    if (step_sweep) begin
      step_cell = 1'b1;
      if (state == yfu_pkg::S_WR || state == yfu_pkg::S_CELL) begin
        state_next = yfu_pkg::S_CELL;
      end
      if (cell_last) begin
        axis_next = (axis == yfu_pkg::AXIS_LAST) ? 2'd0 : axis + 2'd1;
        if (axis == yfu_pkg::AXIS_LAST) begin
          phase_next = yfu_pkg::phase_t'(phase + 2'd1);
          if (phase == yfu_pkg::PH_B2) state_next = yfu_pkg::S_DONE;
        end
      end
    end

    if (step_cell) begin
      k_next = k_last ? '0 : k + 1'b1;
      if (k_last) j_next = j_last ? '0 : j + 1'b1;
      if (k_last && j_last) i_next = i_last ? '0 : i + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: design/yfu_dpath.sv
// Datapath: nine grid memories, configuration registers, operand pipeline
// (difference, multiply, round and accumulate), saturation and result register.
// Depends on yfu_pkg; commanded by yfu_ctrl.
`default_nettype none

module yfu_dpath #(
  parameter int NX = 16,
  parameter int NY = 16,
  parameter int NZ = 16,
  localparam int IW = $clog2(NX + 1),
  localparam int JW = $clog2(NY),
  localparam int KW = $clog2(NZ)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire yfu_pkg::cmd_t      cmd,
  input  wire logic [IW-1:0]      ci,
  input  wire logic [JW-1:0]      cj,
  input  wire logic [KW-1:0]      ck,
  input  wire logic signed [31:0] sample,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output      logic signed [31:0] out_value,
  output      logic               out_flag
);

  localparam int NCELL = (NX + 1) * NY * NZ;
  localparam int AW    = $clog2(NCELL);
  localparam int AccW  = yfu_pkg::ACC_W;
  localparam logic [AW-1:0] PLANE = AW'(NY * NZ);
  localparam logic [AW-1:0] ROW   = AW'(NZ);
  localparam logic signed [AccW-1:0] SAT_HI = AccW'(64'sd2147483647);
  localparam logic signed [AccW-1:0] SAT_LO = AccW'(-64'sd2147483648);

  logic signed [31:0] coef_x, coef_y, coef_z, coef_cur, e0_x, e0_y, e0_z;
  logic signed [31:0] sample_q, res, coef_m, d, areg, sat_val, wdata;
  logic [31:0]        rdata [yfu_pkg::GRIDS];
  logic [yfu_pkg::GRIDS-1:0] we;
  logic               flag, sat_hi, sat_lo;

  logic [JW-1:0] jp, jm, rj;
  logic [KW-1:0] kp, km, rk;
  logic [IW-1:0] ri;
  logic [AW-1:0] rd_addr, wr_addr;

  yfu_pkg::op_t   p1_op;
  yfu_pkg::grid_t p1_grid;
  yfu_pkg::csel_t p1_csel, p2_csel;
  logic           p1_neg, p1_half, p2_valid, p2_neg, p2_half;
  logic           p3_valid, p3_neg, p3_half;
  logic signed [32:0]     diff;
  logic signed [64:0]     prod;
  logic signed [65:0]     rsum;
  logic signed [AccW-1:0] term, acc;

  // periodic neighbors in y and z
  assign jp = (cj == JW'(NY - 1)) ? '0 : cj + 1'b1;
  assign jm = (cj == '0) ? JW'(NY - 1) : cj - 1'b1;
  assign kp = (ck == KW'(NZ - 1)) ? '0 : ck + 1'b1;
  assign km = (ck == '0) ? KW'(NZ - 1) : ck - 1'b1;

  always_comb begin
    ri = ci;
    rj = cj;
    rk = ck;
    unique case (cmd.u.nbr)
      yfu_pkg::N_IP: ri = ci + 1'b1;
      yfu_pkg::N_IM: ri = ci - 1'b1;
      yfu_pkg::N_JP: rj = jp;
      yfu_pkg::N_JM: rj = jm;
      yfu_pkg::N_KP: rk = kp;
      yfu_pkg::N_KM: rk = km;
      default: ;
    endcase
  end

  assign rd_addr = AW'(ri) * PLANE + AW'(rj) * ROW + AW'(rk);
  assign wr_addr = AW'(ci) * PLANE + AW'(cj) * ROW + AW'(ck);

  assign sat_hi  = (acc > SAT_HI);
  assign sat_lo  = (acc < SAT_LO);
  assign sat_val = sat_hi ? 32'sh7fffffff : (sat_lo ? 32'sh80000000 : acc[31:0]);

  always_comb begin
    unique case (cmd.wsrc)
      yfu_pkg::W_ACC:    wdata = sat_val;
      yfu_pkg::W_SAMPLE: wdata = sample_q;
      yfu_pkg::W_E0X:    wdata = e0_x;
      yfu_pkg::W_E0Y:    wdata = e0_y;
      yfu_pkg::W_E0Z:    wdata = e0_z;
      default:           wdata = '0;
    endcase
    for (int g = 0; g < yfu_pkg::GRIDS; g++) begin
      we[g] = cmd.wr_en && (cmd.wsrc == yfu_pkg::W_CLEAR ||
                            cmd.wr_grid == yfu_pkg::grid_t'(4'(g)));
    end
  end

  for (genvar g = 0; g < yfu_pkg::GRIDS; g++) begin : g_mem
    logic [31:0] mem [NCELL];
    always_ff @(posedge clk) begin
      if (we[g]) mem[wr_addr] <= wdata;
      rdata[g] <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x   <= '0;
      coef_y   <= '0;
      coef_z   <= '0;
      coef_cur <= '0;
      e0_x     <= '0;
      e0_y     <= '0;
      e0_z     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        yfu_pkg::CFG_COEF_X: coef_x   <= cfg_data;
        yfu_pkg::CFG_COEF_Y: coef_y   <= cfg_data;
        yfu_pkg::CFG_COEF_Z: coef_z   <= cfg_data;
        yfu_pkg::CFG_CUR:    coef_cur <= cfg_data;
        yfu_pkg::CFG_E0_X:   e0_x     <= cfg_data;
        yfu_pkg::CFG_E0_Y:   e0_y     <= cfg_data;
        yfu_pkg::CFG_E0_Z:   e0_z     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign d = rdata[p1_grid];

  always_comb begin
    unique case (p2_csel)
      yfu_pkg::C_X: coef_m = coef_x;
      yfu_pkg::C_Y: coef_m = coef_y;
      yfu_pkg::C_Z: coef_m = coef_z;
      default:      coef_m = coef_cur;
    endcase
  end

  // round half up: add half an LSB, then arithmetic shift
  assign rsum = 66'(prod) + (p3_half ? 66'sh10000 : 66'sh8000);
  assign term = p3_half ? AccW'(rsum >>> 17) : AccW'(rsum >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_op    <= yfu_pkg::OP_NOP;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      flag     <= 1'b0;
      res      <= '0;
      out_value <= '0;
      out_flag <= 1'b0;
    end else begin
      p1_op    <= cmd.u.op;
      p2_valid <= (p1_op == yfu_pkg::OP_B) || (p1_op == yfu_pkg::OP_J);
      p3_valid <= p2_valid;
      if (cmd.clr_flag) begin
        flag <= 1'b0;
      end else if (cmd.wr_en && cmd.wsrc == yfu_pkg::W_ACC && (sat_hi || sat_lo)) begin
        flag <= 1'b1;
      end
      if (cmd.clr_res) begin
        res <= '0;
      end else if (p1_op == yfu_pkg::OP_RD) begin
        res <= d;
      end
      if (cmd.load_out) begin
        out_value <= res;
        out_flag  <= flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_req) sample_q <= sample;
    p1_grid <= cmd.u.grid;
    p1_csel <= cmd.u.csel;
    p1_neg  <= cmd.u.neg;
    p1_half <= cmd.half;
    if (p1_op == yfu_pkg::OP_A) areg <= d;
    diff    <= (p1_op == yfu_pkg::OP_J) ? 33'(d) : 33'(areg) - 33'(d);
    p2_csel <= p1_csel;
    p2_neg  <= p1_neg;
    p2_half <= p1_half;
    prod    <= coef_m * diff;
    p3_neg  <= p2_neg;
    p3_half <= p2_half;
    if (p1_op == yfu_pkg::OP_OLD) begin
      acc <= AccW'(d);
    end else if (p3_valid) begin
      acc <= p3_neg ? acc - term : acc + term;
    end
  end

endmodule

`default_nettype wire

FILE: design/yfu_checker.sv
// Port-level checks on the request and result channels, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module yfu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] read_value,
  input wire logic        overflow_seen
);

  logic [1:0] pending;

  // beats accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(read_value) && $stable(overflow_seen))
    else $error("result payload changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result beat with no request outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !in_ready)
    else $error("request taken with two results outstanding");

endmodule

bind yee_fdtd_field_update yfu_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .read_value    (rsp.read_value),
  .overflow_seen (rsp.overflow_seen)
);

`default_nettype wire
